[hdl/frustum_sphere_cull_macros.svh]
// Assertion helpers for the frustum sphere cull checker.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef FRUSTUM_SPHERE_CULL_MACROS_SVH
`define FRUSTUM_SPHERE_CULL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FSC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frustum_sphere_cull: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frustum_sphere_cull: next-cycle check failed");

`endif

[hdl/fsc_pkg.sv]
`default_nettype none

package fsc_pkg;

	localparam int NUM_PLANES  = 6;
	localparam int PLANE_IDX_W = 3;
	localparam int MAT_DEPTH   = 16;
	localparam int MAT_IDX_W   = 4;
	// unit length of a normalized normal is 1 << UNIT_SHIFT (Q1.30)
	localparam int UNIT_SHIFT  = 30;
	// width of a raw plane component magnitude
	localparam int MAG_W       = 33;
	localparam logic [47:0] D_MAG_MAX = 48'h7FFF_FFFF_FFFF;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TEST = 1'b1
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		logic signed [47:0] d;
	} plane_t;

	typedef struct packed {
		logic                 en;
		logic [MAT_IDX_W-1:0] idx;
		logic signed [31:0]   value;
	} mat_wr_t;

	typedef struct packed {
		logic                   en;
		logic [PLANE_IDX_W-1:0] idx;
		plane_t                 plane;
	} plane_wr_t;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [30:0]        rad;
		logic               culled;
	} sphere_t;

endpackage

`default_nettype wire

[hdl/frustum_sphere_cull.sv]
// Sphere versus view frustum culling. A load beat (command 0) writes one
// Q16.16 element of the view-projection matrix and answers visible = 0 at
// once; the block then rebuilds all six normalized planes one after another
// in a shared normalize / square-root / divide sequencer, during which no
// beat is taken. A test beat (command 1) sends the sphere down a row of six
// plane cells; one sphere is in flight at a time, so the next beat waits
// until the sphere has left the cell row. The result register lets the next
// beat in while a result waits.
`default_nettype none

module frustum_sphere_cull
	import fsc_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [3:0]                    element_index,
	input  logic signed [31:0]            element_value,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [COORD_WIDTH-1:0] center_z,
	input  logic [30:0]                   radius,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          visible
);

	logic               in_acc;
	logic               load_acc;
	logic               test_acc;
	logic               bld_busy;
	mat_wr_t            mat_wr;
	plane_wr_t          plane_wr;
	logic signed [31:0] cl_x;
	logic signed [31:0] cl_y;
	logic signed [31:0] cl_z;
	logic               head_v_q;
	sphere_t            head_q;
	logic               chain_v [NUM_PLANES+1];
	sphere_t            chain [NUM_PLANES+1];
	logic               chain_busy_q;
	logic               res_fire;
	logic               res_bit;
	logic               out_valid_q;
	logic               visible_q;
	logic               pend_q;
	logic               pend_bit_q;

	assign in_ready = !bld_busy && !chain_busy_q && !pend_q;
	assign in_acc   = in_valid && in_ready;
	assign load_acc = in_acc && (command == CMD_LOAD);
	assign test_acc = in_acc && (command == CMD_TEST);

	assign mat_wr.en    = load_acc;
	assign mat_wr.idx   = element_index;
	assign mat_wr.value = element_value;

	// saturate the center to the signed 32-bit range
	if (COORD_WIDTH > 32) begin : g_wide
		function automatic logic signed [31:0] clamp_coord(
			input logic signed [COORD_WIDTH-1:0] v);
			logic [COORD_WIDTH-32:0] hi;
			hi = v[COORD_WIDTH-1:31];
			if (&hi || !(|hi)) return v[31:0];
			return v[COORD_WIDTH-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		endfunction
		assign cl_x = clamp_coord(center_x);
		assign cl_y = clamp_coord(center_y);
		assign cl_z = clamp_coord(center_z);
	end else begin : g_narrow
		assign cl_x = 32'(center_x);
		assign cl_y = 32'(center_y);
		assign cl_z = 32'(center_z);
	end

	fsc_builder u_builder (
		.clk      (clk),
		.arst_n   (arst_n),
		.mat_wr   (mat_wr),
		.plane_wr (plane_wr),
		.busy     (bld_busy)
	);

	// head of the cell row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q     <= 1'b0;
			chain_busy_q <= 1'b0;
		end else begin
			head_v_q <= test_acc;
			if (test_acc) begin
				chain_busy_q <= 1'b1;
			end else if (chain_v[NUM_PLANES]) begin
				chain_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (test_acc) begin
			head_q <= {cl_x, cl_y, cl_z, radius, 1'b0};
		end
	end

	assign chain_v[0] = head_v_q;
	assign chain[0]   = head_q;

	for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
		fsc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (plane_wr.en && (plane_wr.idx == PLANE_IDX_W'(g))),
			.plane_in  (plane_wr.plane),
			.in_valid  (chain_v[g]),
			.sph_in    (chain[g]),
			.out_valid (chain_v[g+1]),
			.sph_out   (chain[g+1])
		);
	end

	assign res_fire = load_acc || chain_v[NUM_PLANES];
	assign res_bit  = load_acc ? 1'b0 : !chain[NUM_PLANES].culled;

	// result register with one spare slot behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			visible_q   <= 1'b0;
			pend_q      <= 1'b0;
			pend_bit_q  <= 1'b0;
		end else begin
			if (res_fire) begin
				if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1;
					visible_q   <= res_bit;
				end else begin
					pend_q     <= 1'b1;
					pend_bit_q <= res_bit;
				end
			end else if (out_valid_q && out_ready) begin
				if (pend_q) begin
					visible_q <= pend_bit_q;
					pend_q    <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = visible_q;

endmodule

`default_nettype wire

[hdl/fsc_cell.sv]
`default_nettype none

module fsc_cell
	import fsc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  plane_t  plane_in,
	input  logic    in_valid,
	input  sphere_t sph_in,
	output logic    out_valid,
	output sphere_t sph_out
);

	plane_t             plane_q;
	logic               v_s1;
	logic               v_s2;
	sphere_t            sph_s1;
	sphere_t            sph_s2;
	logic signed [63:0] px_s1;
	logic signed [63:0] py_s1;
	logic signed [63:0] pz_s1;
	logic signed [65:0] x_sum;
	logic signed [65:0] fx;
	logic signed [65:0] neg_d;
	logic               cull_here;
	sphere_t            sph_nx;

	// hold this cell's plane, advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (load) begin
				plane_q <= plane_in;
			end
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// dot product, floor to Q35.30, compare against minus d
	always_comb begin
		x_sum = 66'(px_s1) + 66'(py_s1) + 66'(pz_s1) + $signed({5'd0, sph_s1.rad, 30'd0});
		fx = x_sum >>> 16;
		neg_d = -66'(plane_q.d);
		cull_here = fx < neg_d;
		sph_nx        = sph_s1;
		sph_nx.culled = sph_s1.culled | cull_here;
	end

	// stage 1: products; stage 2: accumulate the cull flag
	always_ff @(posedge clk) begin
		px_s1  <= plane_q.nx * sph_in.cx;
		py_s1  <= plane_q.ny * sph_in.cy;
		pz_s1  <= plane_q.nz * sph_in.cz;
		sph_s1 <= sph_in;
		sph_s2 <= sph_nx;
	end

	assign out_valid = v_s2;
	assign sph_out   = sph_s2;

endmodule

`default_nettype wire

[hdl/fsc_builder.sv]
`default_nettype none

module fsc_builder
	import fsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  mat_wr_t   mat_wr,
	output plane_wr_t plane_wr,
	output logic      busy
);

	typedef enum logic [7:0] {
		B_IDLE  = 8'b0000_0001,
		B_RAW   = 8'b0000_0010,
		B_NORM  = 8'b0000_0100,
		B_SQ    = 8'b0000_1000,
		B_SQRT  = 8'b0001_0000,
		B_DINIT = 8'b0010_0000,
		B_DIV   = 8'b0100_0000,
		B_WRITE = 8'b1000_0000
	} bstate_t;

	localparam logic [63:0] SQRT_TOP = 64'h4000_0000_0000_0000;

	bstate_t                state_q;
	logic signed [31:0]     mat_q [MAT_DEPTH];
	logic [PLANE_IDX_W-1:0] plane_q;
	logic [3:0]             neg_q;
	logic [MAG_W-1:0]       mag3_q;
	logic [31:0]            a_q [3];
	logic [30:0]            m_q;
	logic [5:0]             e_q;
	logic [1:0]             sq_cnt_q;
	logic [63:0]            prod_q;
	logic [63:0]            s_q;
	logic [63:0]            res_q;
	logic [4:0]             it_q;
	logic [1:0]             div_idx_q;
	logic [MAG_W-1:0]       dv_q;
	logic [6:0]             cnt_q;
	logic [31:0]            rem_q;
	logic [47:0]            quo_q;
	logic                   ovf_q;
	logic signed [31:0]     nrm_q [3];
	logic signed [47:0]     d_q;
	plane_wr_t              wr_q;

	logic signed [MAG_W-1:0] raw_all [8][4];
	logic signed [MAG_W-1:0] raw [4];
	logic [MAG_W-1:0]        mag [4];
	logic [MAG_W-1:0]        m;
	logic [31:0]             a_sel;
	logic [63:0]             sq_full;
	logic [63:0]             sq_bit;
	logic [64:0]             sq_trial;
	logic [MAG_W-1:0]        dv_start;
	logic [6:0]              cnt_start;
	logic [32:0]             r2;
	logic                    r_ge;
	logic [47:0]             quo_mag;
	logic signed [47:0]      quo_signed;
	logic                    last_plane;
	logic                    wr_en;
	plane_t                  wr_plane;

	// raw plane components for every plane, from the matrix rows
	always_comb begin
		logic signed [MAG_W-1:0] c0, c1, c2, c3;
		for (int j = 0; j < 4; j++) begin
			c0 = MAG_W'(mat_q[4*j]);
			c1 = MAG_W'(mat_q[4*j+1]);
			c2 = MAG_W'(mat_q[4*j+2]);
			c3 = MAG_W'(mat_q[4*j+3]);
			raw_all[0][j] = c3 + c0;
			raw_all[1][j] = c3 - c0;
			raw_all[2][j] = c3 + c1;
			raw_all[3][j] = c3 - c1;
			raw_all[4][j] = c2;
			raw_all[5][j] = c3 - c2;
			raw_all[6][j] = '0;
			raw_all[7][j] = '0;
		end
	end

	// magnitudes of the current plane and the largest normal magnitude
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			raw[j] = raw_all[plane_q][j];
			mag[j] = raw[j][MAG_W-1] ? MAG_W'(-raw[j]) : MAG_W'(raw[j]);
		end
		m = mag[0];
		if (mag[1] > m) m = mag[1];
		if (mag[2] > m) m = mag[2];
	end

	// shared squarer for the sum of squares
	always_comb begin
		case (sq_cnt_q)
			2'd0:    a_sel = a_q[0];
			2'd1:    a_sel = a_q[1];
			2'd2:    a_sel = a_q[2];
			default: a_sel = '0;
		endcase
		sq_full = a_sel * a_sel;
	end

	// one digit of the integer square root per cycle
	always_comb begin
		sq_bit   = SQRT_TOP >> {it_q, 1'b0};
		sq_trial = {1'b0, res_q} + {1'b0, sq_bit};
	end

	// restoring divider, one quotient bit per cycle
	always_comb begin
		case (div_idx_q)
			2'd0:    dv_start = {1'b0, a_q[0]};
			2'd1:    dv_start = {1'b0, a_q[1]};
			2'd2:    dv_start = {1'b0, a_q[2]};
			default: dv_start = mag3_q;
		endcase
		cnt_start  = (div_idx_q == 2'd3) ? 7'(MAG_W) + 7'(e_q) : 7'(MAG_W + UNIT_SHIFT);
		r2         = {rem_q, dv_q[MAG_W-1]};
		r_ge       = r2 >= {1'b0, res_q[31:0]};
		quo_mag    = (ovf_q || quo_q[47]) ? D_MAG_MAX : quo_q;
		quo_signed = neg_q[div_idx_q] ? -$signed(quo_mag) : $signed(quo_mag);
		last_plane = plane_q == PLANE_IDX_W'(NUM_PLANES - 1);
	end

	// stage the plane write: all zero from the raw step, divider results otherwise
	always_comb begin
		wr_en    = (state_q == B_WRITE) || ((state_q == B_RAW) && (m == '0));
		wr_plane = (state_q == B_WRITE) ?
			plane_t'({nrm_q[0], nrm_q[1], nrm_q[2], d_q}) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			for (int i = 0; i < MAT_DEPTH; i++) mat_q[i] <= '0;
			plane_q   <= '0;
			neg_q     <= '0;
			mag3_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				a_q[i]   <= '0;
				nrm_q[i] <= '0;
			end
			m_q       <= '0;
			e_q       <= '0;
			sq_cnt_q  <= '0;
			prod_q    <= '0;
			s_q       <= '0;
			res_q     <= '0;
			it_q      <= '0;
			div_idx_q <= '0;
			dv_q      <= '0;
			cnt_q     <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			ovf_q     <= 1'b0;
			d_q       <= '0;
			wr_q      <= '0;
		end else begin
			wr_q <= {wr_en, plane_q, wr_plane};
			if (mat_wr.en) begin
				mat_q[mat_wr.idx] <= mat_wr.value;
			end
			unique case (state_q)
				B_IDLE: begin
					if (mat_wr.en) begin
						plane_q <= '0;
						state_q <= B_RAW;
					end
				end
				B_RAW: begin
					neg_q  <= {raw[3][MAG_W-1], raw[2][MAG_W-1], raw[1][MAG_W-1],
						raw[0][MAG_W-1]};
					mag3_q <= mag[3];
					if (m == '0) begin
						// zero normal: store an all-zero plane
						if (last_plane) begin
							state_q <= B_IDLE;
						end else begin
							plane_q <= plane_q + 1'b1;
						end
					end else if (m[MAG_W-1:31] != '0) begin
						// too large: halve the normal
						for (int i = 0; i < 3; i++) a_q[i] <= mag[i][MAG_W-1:1];
						e_q      <= 6'(UNIT_SHIFT - 1);
						sq_cnt_q <= '0;
						s_q      <= '0;
						prod_q   <= '0;
						state_q  <= B_SQ;
					end else begin
						for (int i = 0; i < 3; i++) a_q[i] <= mag[i][31:0];
						m_q     <= m[30:0];
						e_q     <= 6'(UNIT_SHIFT);
						state_q <= B_NORM;
					end
				end
				B_NORM: begin
					// shift left until the top normal magnitude reaches bit 30
					if (m_q[30]) begin
						sq_cnt_q <= '0;
						s_q      <= '0;
						prod_q   <= '0;
						state_q  <= B_SQ;
					end else begin
						for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 1;
						m_q <= m_q << 1;
						e_q <= e_q + 1'b1;
					end
				end
				B_SQ: begin
					prod_q   <= sq_full;
					s_q      <= s_q + prod_q;
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == 2'd3) begin
						it_q    <= '0;
						res_q   <= '0;
						state_q <= B_SQRT;
					end
				end
				B_SQRT: begin
					if ({1'b0, s_q} >= sq_trial) begin
						s_q   <= s_q - sq_trial[63:0];
						res_q <= (res_q >> 1) + sq_bit;
					end else begin
						res_q <= res_q >> 1;
					end
					it_q <= it_q + 1'b1;
					if (it_q == 5'd31) begin
						div_idx_q <= '0;
						state_q   <= B_DINIT;
					end
				end
				B_DINIT: begin
					dv_q    <= dv_start;
					cnt_q   <= cnt_start;
					rem_q   <= '0;
					quo_q   <= '0;
					ovf_q   <= 1'b0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					if (cnt_q != '0) begin
						dv_q  <= dv_q << 1;
						cnt_q <= cnt_q - 1'b1;
						ovf_q <= ovf_q | quo_q[47];
						quo_q <= {quo_q[46:0], r_ge};
						rem_q <= r_ge ? 32'(r2 - {1'b0, res_q[31:0]}) : r2[31:0];
					end else begin
						case (div_idx_q)
							2'd0:    nrm_q[0] <= quo_signed[31:0];
							2'd1:    nrm_q[1] <= quo_signed[31:0];
							2'd2:    nrm_q[2] <= quo_signed[31:0];
							default: d_q      <= quo_signed;
						endcase
						if (div_idx_q == 2'd3) begin
							state_q <= B_WRITE;
						end else begin
							div_idx_q <= div_idx_q + 1'b1;
							state_q   <= B_DINIT;
						end
					end
				end
				B_WRITE: begin
					if (last_plane) begin
						state_q <= B_IDLE;
					end else begin
						plane_q <= plane_q + 1'b1;
						state_q <= B_RAW;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign plane_wr = wr_q;
	assign busy     = state_q != B_IDLE;

endmodule

`default_nettype wire

[hdl/fsc_checker.sv]
`default_nettype none
`include "frustum_sphere_cull_macros.svh"

module fsc_checker
	import fsc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic command,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic visible
);

	// one item in flight: no beat right after a taken beat
	`FSC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// a load answers not visible in the very next cycle when the slot is free
	`FSC_ASSERT_NEXT(a_load_result, in_valid && in_ready && command == CMD_LOAD && (!out_valid || out_ready), out_valid && !visible)

	// a sphere test needs the whole cell row; nothing shows up at once
	`FSC_ASSERT_NEXT(a_test_latency, in_valid && in_ready && command == CMD_TEST, !$rose(out_valid))

	// a waiting result holds
	`FSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(visible))

	// ready is checked to be known only in cycles where it is high, outside reset
	`FSC_ASSERT_NOW(a_ready_known, in_ready, !(in_ready === 1'bx))

endmodule

bind frustum_sphere_cull fsc_checker u_fsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.command   (command),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.visible   (visible)
);

`default_nettype wire

[test/frustum_sphere_cull_tb.sv]
`default_nettype none

module frustum_sphere_cull_tb;
	import fsc_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	cmd_t               command;
	logic [3:0]         element_index;
	logic signed [31:0] element_value;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;
	logic signed [31:0] center_z;
	logic [30:0]        radius;
	logic               out_valid;
	logic               out_ready;
	logic               visible;

	// mirror of the block state: Q16.16 matrix, Q17.30 planes
	longint matrix_q16[16];
	longint plane_q30[24];
	bit     visible_due[$];
	int     errors;
	int     stall_hold;

	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
	localparam longint D_SAT = 64'h0000_7FFF_FFFF_FFFF;

	frustum_sphere_cull u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .element_index(element_index),
		.element_value(element_value),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.radius(radius),
		.out_valid(out_valid), .out_ready(out_ready), .visible(visible)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// --- plane extraction and sphere test ---

	function automatic longint unsigned int_sqrt(input longint unsigned s);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	task automatic normalize_plane(input longint raw[4], input int p);
		longint unsigned mag[4], a[3], m, s, len, q, r;
		bit neg[4];
		int e, k;
		m = 0; s = 0; k = 0;
		for (int i = 0; i < 4; i++) begin
			neg[i] = raw[i] < 0;
			mag[i] = neg[i] ? longint'(-raw[i]) : longint'(raw[i]);
		end
		for (int i = 0; i < 3; i++)
			if (mag[i] > m) m = mag[i];
		// zero normal: the plane never culls
		if (m == 0) begin
			for (int i = 0; i < 4; i++) plane_q30[p*4+i] = 0;
			return;
		end
		if (m >= (64'd1 << 31)) begin
			for (int i = 0; i < 3; i++) a[i] = mag[i] >> 1;
			e = 29;
		end else begin
			while ((m << k) < (64'd1 << 30)) k++;
			for (int i = 0; i < 3; i++) a[i] = mag[i] << k;
			e = 30 + k;
		end
		for (int i = 0; i < 3; i++) s += a[i] * a[i];
		len = int_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			q = (a[i] << 30) / len;
			plane_q30[p*4+i] = neg[i] ? -longint'(q) : longint'(q);
		end
		// long division of d, saturate on overflow
		q = mag[3] / len;
		r = mag[3] % len;
		for (int i = 0; i < e; i++) begin
			r <<= 1;
			q <<= 1;
			if (r >= len) begin
				r -= len;
				q |= 1;
			end
			if (q > D_SAT) begin
				q = D_SAT;
				break;
			end
		end
		plane_q30[p*4+3] = neg[3] ? -longint'(q) : longint'(q);
	endtask

	task automatic rebuild_planes();
		longint raw[4];
		longint c0, c1, c2, c3;
		for (int p = 0; p < NUM_PLANES; p++) begin
			for (int j = 0; j < 4; j++) begin
				c0 = matrix_q16[j*4+0];
				c1 = matrix_q16[j*4+1];
				c2 = matrix_q16[j*4+2];
				c3 = matrix_q16[j*4+3];
				case (p)
					0: raw[j] = c3 + c0;
					1: raw[j] = c3 - c0;
					2: raw[j] = c3 + c1;
					3: raw[j] = c3 - c1;
					4: raw[j] = c2;
					default: raw[j] = c3 - c2;
				endcase
			end
			normalize_plane(raw, p);
		end
	endtask

	function automatic bit predict_visible(input longint cx, cy, cz, rad);
		longint x;
		for (int p = 0; p < NUM_PLANES; p++) begin
			x = plane_q30[p*4] * cx + plane_q30[p*4+1] * cy + plane_q30[p*4+2] * cz
				+ (rad <<< 30);
			if ((x >>> 16) < -plane_q30[p*4+3]) return 1'b0;
		end
		return 1'b1;
	endfunction

	// --- stimulus helpers ---

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55) return 0;
		if (sel < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [31:0] rand_elem();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7) return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
		if (sel < 9) return $urandom;
		return 0;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		if ($urandom_range(0, 4) != 0)
			return $signed($urandom_range(0, 32'h100000)) - 32'sh80000;
		return $urandom;
	endfunction

	function automatic logic [30:0] rand_radius();
		if ($urandom_range(0, 9) < 7) return 31'($urandom_range(0, 32'h20000));
		return 31'($urandom);
	endfunction

	// send one beat, predict it on acceptance, then idle a random gap
	task automatic send_beat(input cmd_t cmd, input logic [3:0] idx,
			input logic signed [31:0] val, cx, cy, cz, input logic [30:0] rad);
		int gap;
		command       = cmd;
		element_index = idx;
		element_value = val;
		center_x      = cx;
		center_y      = cy;
		center_z      = cz;
		radius        = rad;
		in_valid      = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (cmd == CMD_LOAD) begin
			matrix_q16[idx] = longint'(val);
			rebuild_planes();
			visible_due = {visible_due, 1'b0};
		end else begin
			visible_due = {visible_due, predict_visible(cx, cy, cz, longint'(rad))};
		end
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic load_elem(input logic [3:0] idx, input logic signed [31:0] val);
		send_beat(CMD_LOAD, idx, val, 0, 0, 0, 31'd0);
	endtask

	task automatic test_sphere(input logic signed [31:0] cx, cy, cz,
			input logic [30:0] rad);
		send_beat(CMD_TEST, 4'd0, 0, cx, cy, cz, rad);
	endtask

	// --- result checking and receiver stalls ---

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (visible_due.size() == 0) begin
				$error("unexpected result beat, visible=%0b", visible);
				errors++;
			end else if (visible !== visible_due[0]) begin
				$error("visible mismatch: expected %0b actual %0b", visible_due[0], visible);
				errors++;
				void'(visible_due.pop_front());
			end else begin
				void'(visible_due.pop_front());
			end
		end
	end

	always @(negedge clk) begin
		if (stall_hold > 0) begin
			out_ready = 1'b0;
			stall_hold--;
		end else if ($urandom_range(0, 99) < 3) begin
			out_ready = 1'b0;
			stall_hold = $urandom_range(5, 30);
		end else begin
			out_ready = $urandom_range(0, 99) < 75;
		end
	end

	// --- tests ---

	task automatic test_reset_state();
		// all-zero planes never cull
		test_sphere(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 31'd0);
		test_sphere(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF);
		// only d set: zero normals everywhere
		load_elem(4'd15, 32'sh7FFF_FFFF);
		test_sphere(-32'sh30000, 0, 0, 31'd0);
	endtask

	task automatic test_identity();
		load_elem(4'd15, ONE_Q16);
		load_elem(4'd0, ONE_Q16);
		load_elem(4'd5, ONE_Q16);
		load_elem(4'd10, ONE_Q16);
		test_sphere(0, 0, 32'sh8000, 31'd0);
		test_sphere(-32'sh30000, 0, 32'sh8000, 31'h10000);
		test_sphere(-32'sh30000, 0, 32'sh8000, 31'h28000);
		test_sphere(0, 32'sh20001, 32'sh8000, 31'h10000);
		test_sphere(0, 0, -32'sh10000, 31'hFFFF);
		test_sphere(0, 0, -32'sh10000, 31'h10000);
	endtask

	task automatic test_extreme_loads();
		// huge normal takes the halving path
		load_elem(4'd0, 32'sh7FFF_FFFF);
		load_elem(4'd3, 32'sh8000_0000);
		test_sphere(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
		test_sphere(32'sh8000_0000, 0, 32'sh8000_0000, 31'd0);
		// tiny normal with huge d saturates the distance
		load_elem(4'd0, 32'sd1);
		load_elem(4'd3, 0);
		load_elem(4'd15, 32'sh8000_0000);
		test_sphere(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'd0);
		load_elem(4'd12, 32'sh7FFF_FFFF);
		test_sphere(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'd0);
	endtask

	task automatic test_backpressure();
		stall_hold = 400;
		repeat (12) test_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius());
	endtask

	task automatic test_random(input int n);
		logic [3:0] idx;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 199) == 0) begin
				// restore a unit frustum so tests keep culling
				for (int k = 0; k < 16; k++) begin
					idx = 4'(k);
					if (k == 0 || k == 5 || k == 10 || k == 15) load_elem(idx, ONE_Q16);
					else if (matrix_q16[k] != 0) load_elem(idx, 0);
				end
			end else if ($urandom_range(0, 99) < 8) begin
				load_elem(4'($urandom_range(0, 15)), rand_elem());
			end else begin
				test_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius());
			end
		end
	endtask

	initial begin
		int waited;
		errors = 0;
		stall_hold = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		command = CMD_LOAD;
		element_index = 0;
		element_value = 0;
		center_x = 0;
		center_y = 0;
		center_z = 0;
		radius = 0;
		for (int i = 0; i < 16; i++) matrix_q16[i] = 0;
		for (int i = 0; i < 24; i++) plane_q30[i] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_identity();
		test_extreme_loads();
		test_backpressure();
		test_random(1860);

		// drain outstanding results, then let any plane rebuild finish
		in_valid = 1'b0;
		waited = 0;
		while (visible_due.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2500) @(posedge clk);
		if (errors == 0 && visible_due.size() == 0) begin
			$display("PASS frustum_sphere_cull");
		end else begin
			$display("FAIL frustum_sphere_cull");
		end
		$finish;
	end

	initial begin
		#60000000;
		$display("FAIL frustum_sphere_cull");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
+incdir+hdl
hdl/fsc_pkg.sv
hdl/fsc_cell.sv
hdl/fsc_builder.sv
hdl/frustum_sphere_cull.sv
hdl/fsc_checker.sv
test/frustum_sphere_cull_tb.sv
